// ===== src/crcfr_pkg.sv =====
// ----------------------------------------------------------------------------
// crcfr_pkg
// Types and constants shared by the CRC-16 frame receiver.
// ----------------------------------------------------------------------------
package crcfr_pkg;

    localparam int MAX_PAYLOAD_DEF = 32;

    // configuration register indexes
    localparam logic CFG_START_FIRST  = 1'b0;
    localparam logic CFG_START_SECOND = 1'b1;

    localparam logic [7:0] START_FIRST_RST  = 8'hAA;
    localparam logic [7:0] START_SECOND_RST = 8'h55;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // input commands
    localparam logic CMD_BYTE  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // result kinds and NACK codes
    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_NACK  = 1'b1;
    localparam logic ERR_LENGTH = 1'b0;
    localparam logic ERR_CRC    = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
    } t_rx_beat;

    typedef struct packed {
        logic       kind;
        logic [7:0] frame_type;
        logic [7:0] frame_command;
        logic [7:0] frame_sequence;
        logic [5:0] payload_length;
        logic [4:0] byte_index;
        logic [7:0] payload_byte;
        logic       error_code;
        logic       last;
    } t_res_beat;

endpackage

// ===== src/crc16_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// crc16_frame_receiver
// Byte-serial parser for start-byte framed packets checked by CRC-16/MODBUS.
// ----------------------------------------------------------------------------
// A byte that enters the CRC (start bytes, header, length, payload) is
// folded in one bit per cycle by a single shift/xor stage, the first bit in
// the accept cycle, the rest in S_CRC. Bytes that do not touch the CRC (CRC
// low byte, ignored hunt bytes, flush) do not leave S_IDLE. After the CRC
// high byte the block streams its results from the payload memory through
// S_FETCH (registered memory read) and S_LOAD (output register load, held
// while the sink stalls); a NACK or an empty-payload result skips S_FETCH.
// No new input beat is taken while results stream.
// ----------------------------------------------------------------------------
module crc16_frame_receiver #(
    parameter int MAX_PAYLOAD = crcfr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  crcfr_pkg::t_rx_beat  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output crcfr_pkg::t_res_beat o_out_data,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [7:0]           i_cfg_data
);
    import crcfr_pkg::*;

    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
    localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CRC   = 4'b0010,
        S_FETCH = 4'b0100,
        S_LOAD  = 4'b1000
    } t_state;

    typedef enum logic [8:0] {
        PH_SOF1    = 9'b0_0000_0001,
        PH_SOF2    = 9'b0_0000_0010,
        PH_TYPE    = 9'b0_0000_0100,
        PH_CMD     = 9'b0_0000_1000,
        PH_SEQ     = 9'b0_0001_0000,
        PH_LEN     = 9'b0_0010_0000,
        PH_PAYLOAD = 9'b0_0100_0000,
        PH_CRC_LO  = 9'b0_1000_0000,
        PH_CRC_HI  = 9'b1_0000_0000
    } t_phase;

    function automatic logic [15:0] crc_bit(input logic [15:0] c);
        return c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    endfunction

    t_state           r_state, n_state;
    t_phase           r_phase, n_phase;
    logic [15:0]      r_crc, n_crc;
    logic [2:0]       r_bit_cnt, n_bit_cnt;
    logic [7:0]       r_sof1, r_sof2;
    logic [7:0]       r_type, n_type;
    logic [7:0]       r_cmd, n_cmd;
    logic [7:0]       r_seq, n_seq;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_count, n_count;
    logic [7:0]       r_crc_lo, n_crc_lo;
    logic [LEN_W-1:0] r_emit_idx, n_emit_idx;
    logic             r_from_mem, n_from_mem;
    logic             r_res_kind, n_res_kind;
    logic             r_res_err, n_res_err;
    logic             r_out_valid, n_out_valid;
    t_res_beat        r_out, n_out;

    logic [7:0]       r_mem [MAX_PAYLOAD];
    logic [7:0]       r_mem_q;
    logic             w_mem_we;

    logic             w_accept;
    logic [7:0]       w_b;
    logic [LEN_W:0]   w_count_inc;
    logic             w_emit_last;
    logic             w_out_free;

    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_b         = i_in_data.rx_byte;
    assign w_count_inc = {1'b0, r_count} + 1'b1;
    assign w_emit_last = (({1'b0, r_emit_idx} + 1'b1) == {1'b0, r_len});
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_mem_we    = w_accept && (i_in_data.command == CMD_BYTE)
                         && (r_phase == PH_PAYLOAD);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_crc       = r_crc;
        n_bit_cnt   = r_bit_cnt;
        n_type      = r_type;
        n_cmd       = r_cmd;
        n_seq       = r_seq;
        n_len       = r_len;
        n_count     = r_count;
        n_crc_lo    = r_crc_lo;
        n_emit_idx  = r_emit_idx;
        n_from_mem  = r_from_mem;
        n_res_kind  = r_res_kind;
        n_res_err   = r_res_err;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in_data.command == CMD_FLUSH) begin
                        n_phase  = PH_SOF1;
                        n_crc    = CRC_INIT;
                        n_type   = '0;
                        n_cmd    = '0;
                        n_seq    = '0;
                        n_len    = '0;
                        n_count  = '0;
                        n_crc_lo = '0;
                    end else begin
                        unique case (r_phase)
                            PH_SOF1: begin
                                if (w_b == r_sof1) begin
                                    n_type    = '0;
                                    n_cmd     = '0;
                                    n_seq     = '0;
                                    n_len     = '0;
                                    n_count   = '0;
                                    n_crc_lo  = '0;
                                    n_crc     = crc_bit(CRC_INIT ^ {8'h00, w_b});
                                    n_bit_cnt = '0;
                                    n_phase   = PH_SOF2;
                                    n_state   = S_CRC;
                                end
                            end
                            PH_SOF2: begin
                                if (w_b == r_sof2) begin
                                    n_crc     = crc_bit(r_crc ^ {8'h00, w_b});
                                    n_bit_cnt = '0;
                                    n_phase   = PH_TYPE;
                                    n_state   = S_CRC;
                                end else if (w_b == r_sof1) begin
                                    // repeated first start byte: restart the hunt
                                    n_crc     = crc_bit(CRC_INIT ^ {8'h00, w_b});
                                    n_bit_cnt = '0;
                                    n_state   = S_CRC;
                                end else begin
                                    n_phase  = PH_SOF1;
                                    n_crc    = CRC_INIT;
                                    n_count  = '0;
                                    n_crc_lo = '0;
                                end
                            end
                            PH_TYPE, PH_CMD, PH_SEQ: begin
                                if (r_phase == PH_TYPE) begin
                                    n_type  = w_b;
                                    n_phase = PH_CMD;
                                end else if (r_phase == PH_CMD) begin
                                    n_cmd   = w_b;
                                    n_phase = PH_SEQ;
                                end else begin
                                    n_seq   = w_b;
                                    n_phase = PH_LEN;
                                end
                                n_crc     = crc_bit(r_crc ^ {8'h00, w_b});
                                n_bit_cnt = '0;
                                n_state   = S_CRC;
                            end
                            PH_LEN: begin
                                if (w_b > MAX_LEN) begin
                                    n_from_mem = 1'b0;
                                    n_res_kind = KIND_NACK;
                                    n_res_err  = ERR_LENGTH;
                                    n_state    = S_LOAD;
                                end else begin
                                    n_len     = LEN_W'(w_b);
                                    n_count   = '0;
                                    n_crc     = crc_bit(r_crc ^ {8'h00, w_b});
                                    n_bit_cnt = '0;
                                    n_phase   = (w_b == 8'h00) ? PH_CRC_LO : PH_PAYLOAD;
                                    n_state   = S_CRC;
                                end
                            end
                            PH_PAYLOAD: begin
                                n_count   = w_count_inc[LEN_W-1:0];
                                n_crc     = crc_bit(r_crc ^ {8'h00, w_b});
                                n_bit_cnt = '0;
                                n_state   = S_CRC;
                                if (w_count_inc >= {1'b0, r_len}) begin
                                    n_phase = PH_CRC_LO;
                                end
                            end
                            PH_CRC_LO: begin
                                n_crc_lo = w_b;
                                n_phase  = PH_CRC_HI;
                            end
                            PH_CRC_HI: begin
                                n_emit_idx = '0;
                                if ({w_b, r_crc_lo} == r_crc) begin
                                    n_res_kind = KIND_DATA;
                                    n_res_err  = ERR_LENGTH;
                                    if (r_len == '0) begin
                                        n_from_mem = 1'b0;
                                        n_state    = S_LOAD;
                                    end else begin
                                        n_from_mem = 1'b1;
                                        n_state    = S_FETCH;
                                    end
                                end else begin
                                    n_from_mem = 1'b0;
                                    n_res_kind = KIND_NACK;
                                    n_res_err  = ERR_CRC;
                                    n_state    = S_LOAD;
                                end
                            end
                            default: begin
                                n_phase  = PH_SOF1;
                                n_crc    = CRC_INIT;
                                n_type   = '0;
                                n_cmd    = '0;
                                n_seq    = '0;
                                n_len    = '0;
                                n_count  = '0;
                                n_crc_lo = '0;
                            end
                        endcase
                    end
                end
            end
            S_CRC: begin
                // advance the CRC one bit per cycle
                n_crc     = crc_bit(r_crc);
                n_bit_cnt = r_bit_cnt + 3'd1;
                if (r_bit_cnt == 3'd6) begin
                    n_state = S_IDLE;
                end
            end
            S_FETCH: begin
                // wait for the registered memory read
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (w_out_free) begin
                    n_out_valid          = 1'b1;
                    n_out.kind           = r_res_kind;
                    n_out.frame_command  = r_cmd;
                    n_out.frame_sequence = r_seq;
                    n_out.error_code     = r_res_err;
                    if (r_from_mem) begin
                        n_out.frame_type     = r_type;
                        n_out.payload_length = 6'(r_len);
                        n_out.byte_index     = 5'(r_emit_idx);
                        n_out.payload_byte   = r_mem_q;
                        n_out.last           = w_emit_last;
                    end else begin
                        n_out.frame_type     = (r_res_kind == KIND_NACK) ? 8'h00 : r_type;
                        n_out.payload_length = '0;
                        n_out.byte_index     = '0;
                        n_out.payload_byte   = '0;
                        n_out.last           = 1'b1;
                    end
                    if (r_from_mem && !w_emit_last) begin
                        n_emit_idx = r_emit_idx + 1'b1;
                        n_state    = S_FETCH;
                    end else begin
                        // frame done: drop back to the hunt
                        n_state  = S_IDLE;
                        n_phase  = PH_SOF1;
                        n_crc    = CRC_INIT;
                        n_type   = '0;
                        n_cmd    = '0;
                        n_seq    = '0;
                        n_len    = '0;
                        n_count  = '0;
                        n_crc_lo = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_SOF1;
            r_crc       <= CRC_INIT;
            r_bit_cnt   <= '0;
            r_sof1      <= START_FIRST_RST;
            r_sof2      <= START_SECOND_RST;
            r_type      <= '0;
            r_cmd       <= '0;
            r_seq       <= '0;
            r_len       <= '0;
            r_count     <= '0;
            r_crc_lo    <= '0;
            r_emit_idx  <= '0;
            r_from_mem  <= 1'b0;
            r_res_kind  <= KIND_DATA;
            r_res_err   <= ERR_LENGTH;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_crc       <= n_crc;
            r_bit_cnt   <= n_bit_cnt;
            r_type      <= n_type;
            r_cmd       <= n_cmd;
            r_seq       <= n_seq;
            r_len       <= n_len;
            r_count     <= n_count;
            r_crc_lo    <= n_crc_lo;
            r_emit_idx  <= n_emit_idx;
            r_from_mem  <= n_from_mem;
            r_res_kind  <= n_res_kind;
            r_res_err   <= n_res_err;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_START_FIRST) begin
                    r_sof1 <= i_cfg_data;
                end else begin
                    r_sof2 <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // payload memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_count[IDX_W-1:0]] <= w_b;
        end
        r_mem_q <= r_mem[r_emit_idx[IDX_W-1:0]];
    end

endmodule
